// ----- rtl/core/adlk_pkg.sv -----
// adlk_pkg: shared types, widths and codes for the ladder keypad event decoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package adlk_pkg;

    localparam int NUM_LEVELS_DEF = 5;
    localparam int MAX_LEVELS     = 8;
    localparam int LVL_W          = 3;
    localparam int KIND_W         = 2;
    localparam int SAMPLE_W       = 10;
    localparam int STAMP_W        = 32;
    localparam int MS_W           = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int Q_DEPTH        = 4;

    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DOUBLE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_THR0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POLL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LONG   = 3'd6;

    localparam logic [SAMPLE_W-1:0] THR0_RST   = 10'd861;
    localparam logic [SAMPLE_W-1:0] THR1_RST   = 10'd615;
    localparam logic [SAMPLE_W-1:0] THR2_RST   = 10'd371;
    localparam logic [SAMPLE_W-1:0] THR3_RST   = 10'd125;
    localparam logic [MS_W-1:0]     POLL_RST   = 16'd100;
    localparam logic [MS_W-1:0]     DOUBLE_RST = 16'd500;
    localparam logic [MS_W-1:0]     LONG_RST   = 16'd1000;

    // one queued command: a single event, or a set of releases (high to low)
    typedef struct packed {
        logic                  is_rel;
        logic [KIND_W-1:0]     kind;
        logic [LVL_W-1:0]      key;
        logic [MAX_LEVELS-1:0] rel_mask;
    } adlk_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/adc_ladder_keypad_events.sv -----
// adc_ladder_keypad_events: top level of the ladder keypad event decoder.
// Instantiates adlk_front, adlk_fifo and adlk_back; depends on adlk_pkg.
//
//   channel  handshake               payload
//   cfg      cfg_we                  cfg_index, cfg_data
//   in       in_valid / in_stall     now_ms, sample
//   out      out_valid / out_stall   event_kind, key_level, last_of_run
//
// The front handles each sample in two steps (capture, then evaluate), set by its
// two-state sequencer; a full command queue holds it in evaluate while it has a
// command to push. The back sends one event beat per cycle while out_stall is low;
// a falling level gives one beat per released key.
// Reset clears all key state; configuration returns to its defaults.
// out_stall backs up the output register, then the 4-entry queue, then in_stall.
`default_nettype none
module adc_ladder_keypad_events #(
    parameter int NUM_LEVELS = adlk_pkg::NUM_LEVELS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire  [adlk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [adlk_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire  [adlk_pkg::STAMP_W-1:0]     now_ms,
    input  wire  [adlk_pkg::SAMPLE_W-1:0]    sample,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [adlk_pkg::KIND_W-1:0]      event_kind,
    output logic [adlk_pkg::LVL_W-1:0]       key_level,
    output logic                             last_of_run
);
    import adlk_pkg::*;

    logic      fq_valid, fq_stall, qb_valid, qb_stall;
    adlk_cmd_t fq_data, qb_data;

    adlk_front #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .now_ms    (now_ms),
        .sample    (sample),
        .q_valid   (fq_valid),
        .q_stall   (fq_stall),
        .q_data    (fq_data)
    );

    adlk_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_stall (fq_stall),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_stall (qb_stall),
        .rd_data  (qb_data)
    );

    adlk_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (qb_valid),
        .q_stall     (qb_stall),
        .q_data      (qb_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .key_level   (key_level),
        .last_of_run (last_of_run)
    );

endmodule
`default_nettype wire

// ----- rtl/core/adlk_front.sv -----
// adlk_front: config registers, poll gating, level classification and key state.
// Emits at most one command per due sample into the queue. Depends on adlk_pkg.
`default_nettype none
module adlk_front #(
    parameter int NUM_LEVELS = adlk_pkg::NUM_LEVELS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire  [adlk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [adlk_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire  [adlk_pkg::STAMP_W-1:0]     now_ms,
    input  wire  [adlk_pkg::SAMPLE_W-1:0]    sample,
    output logic                             q_valid,
    input  wire                              q_stall,
    output adlk_pkg::adlk_cmd_t              q_data
);
    import adlk_pkg::*;

    localparam int IDX_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(NUM_LEVELS - 1);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    logic [SAMPLE_W-1:0] thr0_reg, thr1_reg, thr2_reg, thr3_reg;
    logic [MS_W-1:0]     poll_reg, dbl_reg, long_reg;

    logic                  state_reg, state_next;
    logic [STAMP_W-1:0]    now_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [STAMP_W-1:0]    poll_stamp_reg, poll_stamp_next;
    logic [STAMP_W-1:0]    rel_stamp_reg, rel_stamp_next;
    logic [STAMP_W-1:0]    rep_stamp_reg, rep_stamp_next;
    logic [LVL_W-1:0]      prev_reg, prev_next;
    logic [LVL_W-1:0]      last_rel_reg, last_rel_next;
    logic [NUM_LEVELS-1:0] held_reg, held_next;

    logic [STAMP_W-1:0]    diff_poll, diff_rel, diff_rep;
    logic [LVL_W-1:0]      lvl_raw, lvl;
    logic                  due, rise, fall, long_hit, dbl_hit, push_c;
    logic [NUM_LEVELS-1:0] rel_mask;
    logic [LVL_W-1:0]      lowest_rel;
    logic [NUM_LEVELS-1:0] above_prev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr0_reg <= THR0_RST;
            thr1_reg <= THR1_RST;
            thr2_reg <= THR2_RST;
            thr3_reg <= THR3_RST;
            poll_reg <= POLL_RST;
            dbl_reg  <= DOUBLE_RST;
            long_reg <= LONG_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THR0:   thr0_reg <= cfg_data[SAMPLE_W-1:0];
                REG_THR1:   thr1_reg <= cfg_data[SAMPLE_W-1:0];
                REG_THR2:   thr2_reg <= cfg_data[SAMPLE_W-1:0];
                REG_THR3:   thr3_reg <= cfg_data[SAMPLE_W-1:0];
                REG_POLL:   poll_reg <= cfg_data;
                REG_DOUBLE: dbl_reg  <= cfg_data;
                REG_LONG:   long_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign diff_poll = now_reg - poll_stamp_reg;
    assign diff_rel  = now_reg - rel_stamp_reg;
    assign diff_rep  = now_reg - rep_stamp_reg;
    assign due       = diff_poll > STAMP_W'(poll_reg);

    always_comb
    begin
        priority if (sample_reg > thr0_reg) lvl_raw = LVL_W'(0);
        else if (sample_reg > thr1_reg)     lvl_raw = LVL_W'(1);
        else if (sample_reg > thr2_reg)     lvl_raw = LVL_W'(2);
        else if (sample_reg > thr3_reg)     lvl_raw = LVL_W'(3);
        else                                lvl_raw = LVL_W'(4);
    end

    assign lvl      = (lvl_raw > LVL_MAX) ? LVL_MAX : lvl_raw;
    assign rise     = lvl > prev_reg;
    assign fall     = lvl < prev_reg;
    assign long_hit = !rise && !fall && (lvl != '0) && (diff_rep > STAMP_W'(long_reg));
    assign dbl_hit  = (last_rel_reg == lvl) && (diff_rel < STAMP_W'(dbl_reg));

    always_comb
    begin
        rel_mask   = '0;
        lowest_rel = last_rel_reg;
        for (int j = NUM_LEVELS - 1; j >= 0; j--)
        begin
            rel_mask[j] = held_reg[j] && (LVL_W'(j) > lvl) && (LVL_W'(j) <= prev_reg);
            if (rel_mask[j])
                lowest_rel = LVL_W'(j);
        end
    end

    assign push_c = due && (rise || long_hit || (fall && (rel_mask != '0)));

    always_comb
    begin
        q_data.is_rel   = fall;
        q_data.kind     = rise ? (dbl_hit ? KIND_DOUBLE : KIND_PRESS) : KIND_LONG;
        q_data.key      = lvl;
        q_data.rel_mask = MAX_LEVELS'(rel_mask);
    end

    assign q_valid  = (state_reg == ST_EVAL) && push_c;
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        poll_stamp_next = poll_stamp_reg;
        rel_stamp_next  = rel_stamp_reg;
        rep_stamp_next  = rep_stamp_reg;
        prev_next       = prev_reg;
        last_rel_next   = last_rel_reg;
        held_next       = held_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!push_c || !q_stall)
                begin
                    state_next = ST_IDLE;
                    if (due)
                    begin
                        poll_stamp_next = now_reg;
                        prev_next       = lvl;
                        if (rise || fall)
                            rep_stamp_next = now_reg;
                        if (long_hit)
                            rep_stamp_next = now_reg;
                        if (rise)
                            held_next[lvl[IDX_W-1:0]] = 1'b1;
                        if (fall)
                        begin
                            held_next = held_reg & ~rel_mask;
                            if (rel_mask != '0)
                            begin
                                last_rel_next  = lowest_rel;
                                rel_stamp_next = now_reg;
                            end
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            poll_stamp_reg <= '0;
            rel_stamp_reg  <= '0;
            rep_stamp_reg  <= '0;
            prev_reg       <= '0;
            last_rel_reg   <= '0;
            held_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            poll_stamp_reg <= poll_stamp_next;
            rel_stamp_reg  <= rel_stamp_next;
            rep_stamp_reg  <= rep_stamp_next;
            prev_reg       <= prev_next;
            last_rel_reg   <= last_rel_next;
            held_reg       <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            now_reg    <= now_ms;
            sample_reg <= sample;
        end
    end

    always_comb
    begin
        for (int j = 0; j < NUM_LEVELS; j++)
            above_prev[j] = LVL_W'(j) > prev_reg;
    end

    // marks only exist at levels from one up to the previous level in prev_reg
    a_marks_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ((held_reg & above_prev) == '0) && !held_reg[0])
        else $error("key mark outside held range");

    a_prev_capped: assert property (@(posedge clk) disable iff (!rst_n)
        prev_reg <= LVL_MAX)
        else $error("previous level above cap");

endmodule
`default_nettype wire

// ----- rtl/core/adlk_fifo.sv -----
// adlk_fifo: short command queue between front and back, valid/stall both sides.
// Depends on adlk_pkg for the command type and depth.
`default_nettype none
module adlk_fifo (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  wr_valid,
    output logic                 wr_stall,
    input  wire adlk_pkg::adlk_cmd_t wr_data,
    output logic                 rd_valid,
    input  wire                  rd_stall,
    output adlk_pkg::adlk_cmd_t  rd_data
);
    import adlk_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    adlk_cmd_t          mem_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign wr_stall = (count_reg == CNT_W'(Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_W'(Q_DEPTH)) &&
        (PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[PTR_W-1:0]))
        else $error("queue pointers and count disagree");

endmodule
`default_nettype wire

// ----- rtl/core/adlk_back.sv -----
// adlk_back: expands queued commands into event beats, releases from high to low.
// Holds the output register. Depends on adlk_pkg.
`default_nettype none
module adlk_back (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            q_valid,
    output logic                           q_stall,
    input  wire adlk_pkg::adlk_cmd_t       q_data,
    output logic                           out_valid,
    input  wire                            out_stall,
    output logic [adlk_pkg::KIND_W-1:0]    event_kind,
    output logic [adlk_pkg::LVL_W-1:0]     key_level,
    output logic                           last_of_run
);
    import adlk_pkg::*;

    adlk_cmd_t             cmd_reg, cmd_next;
    logic                  cmd_valid_reg, cmd_valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [LVL_W-1:0]      key_reg, key_next;
    logic                  last_reg, last_next;

    logic                  out_load, finish, cmd_free;
    logic [LVL_W-1:0]      hi;
    logic [MAX_LEVELS-1:0] remaining;

    always_comb
    begin
        hi = '0;
        for (int j = 0; j < MAX_LEVELS; j++)
            if (cmd_reg.rel_mask[j])
                hi = LVL_W'(j);
    end

    assign remaining = cmd_reg.rel_mask & ~(MAX_LEVELS'(1) << hi);
    assign out_load  = !out_valid_reg || !out_stall;
    assign finish    = out_load && cmd_valid_reg && (!cmd_reg.is_rel || (remaining == '0));
    assign cmd_free  = !cmd_valid_reg || finish;
    assign q_stall   = !cmd_free;

    always_comb
    begin
        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        last_next      = last_reg;
        if (out_load)
        begin
            out_valid_next = cmd_valid_reg;
            if (cmd_reg.is_rel)
            begin
                kind_next         = KIND_RELEASE;
                key_next          = hi;
                last_next         = (remaining == '0);
                cmd_next.rel_mask = remaining;
            end
            else
            begin
                kind_next = cmd_reg.kind;
                key_next  = cmd_reg.key;
                last_next = 1'b1;
            end
        end
        if (finish)
            cmd_valid_next = 1'b0;
        if (cmd_free && q_valid)
        begin
            cmd_next       = q_data;
            cmd_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        kind_reg <= kind_next;
        key_reg  <= key_next;
        last_reg <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign event_kind  = kind_reg;
    assign key_level   = key_reg;
    assign last_of_run = last_reg;

    a_rel_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid_reg && cmd_reg.is_rel) |-> (cmd_reg.rel_mask != '0))
        else $error("empty release command held");

    a_key_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (key_reg != '0))
        else $error("event beat for key zero");

endmodule
`default_nettype wire
